// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/fpd_pkg.sv =====
// Types and constants of the fingerprint packet deframer.
`default_nettype none
package fpd_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned ADDR_W      = 32;
   localparam int unsigned LENGTH_W    = 16;
   localparam int unsigned CSR_INDEX_W = 8;

   localparam logic [BYTE_W-1:0] HDR0 = 8'hEF;
   localparam logic [BYTE_W-1:0] HDR1 = 8'h01;

   typedef enum logic [2:0] {
      EV_NONE  = 3'd0,
      EV_PAY   = 3'd1,
      EV_GOOD  = 3'd2,
      EV_BADCS = 3'd3,
      EV_BADLN = 3'd4
   } event_kind_type;

   typedef enum logic [2:0] {
      CLS_COMMAND = 3'd0,
      CLS_DATA    = 3'd1,
      CLS_ACK     = 3'd2,
      CLS_END     = 3'd3,
      CLS_UNKNOWN = 3'd4
   } packet_class_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CODE_COMMAND = 8'd0,
      CSR_CODE_DATA    = 8'd1,
      CSR_CODE_ACK     = 8'd2,
      CSR_CODE_END     = 8'd3
   } csr_index_type;

endpackage
`default_nettype wire

// ===== hw/rtl/fpd_req_if.sv =====
// Received-byte channel of the deframer.
`default_nettype none
interface fpd_req_if import fpd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/fpd_rsp_if.sv =====
// Result channel of the deframer.
`default_nettype none
interface fpd_rsp_if import fpd_pkg::*; ();
   logic                valid;
   logic                ready;
   event_kind_type      event_kind;
   logic [BYTE_W-1:0]   payload_byte;
   logic [BYTE_W-1:0]   payload_index;
   logic [ADDR_W-1:0]   frame_address;
   packet_class_type    packet_class;
   logic [LENGTH_W-1:0] frame_length;

   modport source (output valid, output event_kind, output payload_byte,
                   output payload_index, output frame_address, output packet_class,
                   output frame_length, input ready);
   modport sink   (input valid, input event_kind, input payload_byte,
                   input payload_index, input frame_address, input packet_class,
                   input frame_length, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/fpd_csr_if.sv =====
// Register write channel of the deframer.
`default_nettype none
interface fpd_csr_if import fpd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [BYTE_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/fingerprint_packet_deframer.sv =====
// Fingerprint packet deframer: one received byte in, one result out.
//
// The req channel carries received bytes; every accepted byte gives exactly one
// result on the rsp channel: nothing, a payload byte with its index, frame good,
// bad checksum or bad length, together with the address, packet class and
// length as currently held. The parser hunts for EF 01, gathers address,
// identifier and length, streams the payload and checks the 16-bit sum.
// The csr channel writes the four identifier codes; it is always ready and
// should only be used while the block is idle.
// The result of a byte is in the output register in the cycle after its
// transfer. While results are taken, a byte can be taken in every cycle; the
// parse state update and one 16-bit add sit between state and output registers.
// When the receiver stalls, the result waits in the output register and req
// ready stays low until it is taken (ready follows rsp ready combinationally).
// Reset clears the parser to header hunting, zeroes the held fields and loads
// the identifier codes with 1, 2, 7 and 8.
`default_nettype none
module fingerprint_packet_deframer import fpd_pkg::*; #(
   parameter int unsigned MAX_LENGTH = 256
) (
   input  wire      clock,
   input  wire      reset,
   fpd_req_if.sink  req,
   fpd_rsp_if.source rsp,
   fpd_csr_if.sink  csr
);

   localparam int unsigned CNT_W = (MAX_LENGTH > 2) ? $clog2(MAX_LENGTH) : 1;

   typedef enum logic [3:0] {
      ST_EF   = 4'd0,
      ST_01   = 4'd1,
      ST_A0   = 4'd2,
      ST_A1   = 4'd3,
      ST_A2   = 4'd4,
      ST_A3   = 4'd5,
      ST_ID   = 4'd6,
      ST_L0   = 4'd7,
      ST_L1   = 4'd8,
      ST_DATA = 4'd9,
      ST_C0   = 4'd10,
      ST_C1   = 4'd11
   } step_type;

   step_type              step_ff, step_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   packet_class_type      class_ff, class_in;
   logic [LENGTH_W-1:0]   length_ff, length_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [LENGTH_W-1:0]   sum_ff, sum_in;
   logic [BYTE_W-1:0]     check_ff, check_in;

   logic [BYTE_W-1:0]     code_command_ff, code_data_ff, code_ack_ff, code_end_ff;

   logic                  rsp_valid_ff;
   event_kind_type        kind_ff, kind_in;
   logic [BYTE_W-1:0]     pbyte_ff, pbyte_in;
   logic [BYTE_W-1:0]     pidx_ff, pidx_in;

   logic                  accept;
   logic [BYTE_W-1:0]     b;
   logic [CNT_W:0]        count_plus;
   logic [31:0]           count_wide;
   logic [LENGTH_W-1:0]   sum_add;
   logic [LENGTH_W-1:0]   length_full;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign b         = req.rx_byte;
   assign csr.ready = 1'b1;

   assign count_plus  = {1'b0, count_ff} + 1'b1;
   assign count_wide  = 32'(count_ff);
   assign sum_add     = sum_ff + LENGTH_W'(b);
   assign length_full = {length_ff[LENGTH_W-1:BYTE_W], b};

   always_comb begin
      step_in  = step_ff;
      addr_in  = addr_ff;
      class_in = class_ff;
      length_in = length_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      check_in = check_ff;
      kind_in  = EV_NONE;
      pbyte_in = '0;
      pidx_in  = '0;
      unique case (step_ff)
         ST_01: begin
            step_in = (b == HDR1) ? ST_A0 : ST_EF;
         end
         ST_A0: begin
            addr_in = {b, 24'd0};
            step_in = ST_A1;
         end
         ST_A1: begin
            addr_in = {addr_ff[31:24], b, addr_ff[15:0]};
            step_in = ST_A2;
         end
         ST_A2: begin
            addr_in = {addr_ff[31:16], b, addr_ff[7:0]};
            step_in = ST_A3;
         end
         ST_A3: begin
            addr_in = {addr_ff[31:8], b};
            step_in = ST_ID;
         end
         ST_ID: begin
            sum_in = LENGTH_W'(b);
            priority if (b == code_command_ff) class_in = CLS_COMMAND;
            else if (b == code_data_ff)        class_in = CLS_DATA;
            else if (b == code_ack_ff)         class_in = CLS_ACK;
            else if (b == code_end_ff)         class_in = CLS_END;
            else                               class_in = CLS_UNKNOWN;
            step_in = ST_L0;
         end
         ST_L0: begin
            sum_in    = sum_add;
            length_in = {b, 8'd0};
            step_in   = ST_L1;
         end
         ST_L1: begin
            sum_in    = sum_add;
            length_in = length_full;
            count_in  = '0;
            if (length_full > LENGTH_W'(MAX_LENGTH) || length_full < 16'd2) begin
               kind_in = EV_BADLN;
               step_in = ST_EF;
            end else if (length_full == 16'd2) begin
               step_in = ST_C0;
            end else begin
               step_in = ST_DATA;
            end
         end
         ST_DATA: begin
            sum_in   = sum_add;
            kind_in  = EV_PAY;
            pbyte_in = b;
            pidx_in  = count_wide[7:0];
            count_in = count_plus[CNT_W-1:0];
            // Length is at least three here, so the subtraction cannot wrap.
            if (17'(count_plus) >= 17'(length_ff) - 17'd2) begin
               step_in = ST_C0;
            end
         end
         ST_C0: begin
            check_in = b;
            step_in  = ST_C1;
         end
         ST_C1: begin
            kind_in = ({check_ff, b} == sum_ff) ? EV_GOOD : EV_BADCS;
            step_in = ST_EF;
         end
         default: begin
            // Header hunting; step codes that name no step land here as well.
            step_in = (b == HDR0) ? ST_01 : ST_EF;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= ST_EF;
         addr_ff   <= '0;
         class_ff  <= CLS_COMMAND;
         length_ff <= '0;
         count_ff  <= '0;
         sum_ff    <= '0;
         check_ff  <= '0;
      end else if (accept) begin
         step_ff   <= step_in;
         addr_ff   <= addr_in;
         class_ff  <= class_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         check_ff  <= check_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_command_ff <= 8'd1;
         code_data_ff    <= 8'd2;
         code_ack_ff     <= 8'd7;
         code_end_ff     <= 8'd8;
      end else if (csr.valid) begin
         unique case (csr.index)
            CSR_CODE_COMMAND: code_command_ff <= csr.data;
            CSR_CODE_DATA:    code_data_ff    <= csr.data;
            CSR_CODE_ACK:     code_ack_ff     <= csr.data;
            CSR_CODE_END:     code_end_ff     <= csr.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload; the held fields are taken as they stand after the byte.
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= kind_in;
         pbyte_ff <= pbyte_in;
         pidx_ff  <= pidx_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.event_kind    = kind_ff;
   assign rsp.payload_byte  = pbyte_ff;
   assign rsp.payload_index = pidx_ff;
   assign rsp.frame_address = addr_ff;
   assign rsp.packet_class  = class_ff;
   assign rsp.frame_length  = length_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/fpd_checker.sv =====
// Port-level checks of the deframer, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module fpd_checker import fpd_pkg::*; (
   input wire                clock,
   input wire                reset,
   input wire                req_valid,
   input wire                req_ready,
   input wire                rsp_valid,
   input wire                rsp_ready,
   input wire [2:0]          event_kind,
   input wire [BYTE_W-1:0]   payload_byte,
   input wire [BYTE_W-1:0]   payload_index,
   input wire [2:0]          packet_class
);

   // A stalled result must neither vanish nor change.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(event_kind) && $stable(payload_byte))

   // Every byte transfer leaves a result in the output register.
   `ASSERT_NEXT(a_result_follows, clock, reset, req_valid && req_ready, rsp_valid)

   // A byte is refused only while an untaken result is waiting.
   `ASSERT_SAME(a_ready_when_free, clock, reset, !rsp_valid, req_ready)

   // Only payload results carry a byte and an index.
   `ASSERT_SAME(a_payload_zero, clock, reset, rsp_valid && event_kind != EV_PAY,
      payload_byte == 8'd0 && payload_index == 8'd0)

   `ASSERT_SAME(a_codes_legal, clock, reset, rsp_valid,
      event_kind <= 3'd4 && packet_class <= 3'd4)

endmodule

bind fingerprint_packet_deframer fpd_checker u_fpd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .event_kind    (rsp.event_kind),
   .payload_byte  (rsp.payload_byte),
   .payload_index (rsp.payload_index),
   .packet_class  (rsp.packet_class)
);
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the fingerprint packet deframer.
module tb;
   import fpd_pkg::*;

   localparam int FRAME_MAX       = 256;
   localparam int ITEMS_PER_PHASE = 400;
   localparam int N_PHASES        = 5;
   localparam int LIMIT_CYCLES    = 500_000;
   localparam int PRESSURE_AT     = 500;
   localparam int PRESSURE_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 3;
   localparam int MAX_PRINTED     = 40;

   typedef enum logic [3:0] {
      P_HDR0, P_HDR1, P_ADDR0, P_ADDR1, P_ADDR2, P_ADDR3, P_IDENT,
      P_LEN_HI, P_LEN_LO, P_PAYLOAD, P_SUM_HI, P_SUM_LO
   } parse_step_type;

   typedef struct packed {
      event_kind_type      kind;
      logic [7:0]          pay_byte;
      logic [7:0]          pay_index;
      logic [31:0]         address;
      packet_class_type    cls;
      logic [15:0]         length;
   } deframe_result_type;

   typedef struct packed {
      logic [7:0]     rx;
      logic           typed;
      event_kind_type kind;
   } directed_row_type;

   logic clock;
   logic reset;

   fpd_req_if req_if ();
   fpd_rsp_if rsp_if ();
   fpd_csr_if csr_if ();

   fingerprint_packet_deframer #(.MAX_LENGTH(FRAME_MAX)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   // Parser state as the predictor sees it.
   parse_step_type   step;
   logic [31:0]      addr_held;
   packet_class_type cls_held;
   logic [15:0]      len_held;
   int               pay_count;
   logic [15:0]      sum_acc;
   logic [7:0]       chk_hi;
   logic [7:0]       ident_code [4];

   deframe_result_type pending_results [$];
   directed_row_type   directed_rows [24];
   int                 mismatch_count;
   int                 bytes_sent;
   int                 results_taken;
   int                 cycle_count;
   bit                 sender_calm;
   bit                 receiver_calm;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic packet_class_type classify(input logic [7:0] b);
      if (b == ident_code[CSR_CODE_COMMAND]) return CLS_COMMAND;
      if (b == ident_code[CSR_CODE_DATA]) return CLS_DATA;
      if (b == ident_code[CSR_CODE_ACK]) return CLS_ACK;
      if (b == ident_code[CSR_CODE_END]) return CLS_END;
      return CLS_UNKNOWN;
   endfunction

   function automatic int draw_gap(input bit calm);
      if (calm) return 0;
      return $urandom_range(0, 15);
   endfunction

   task automatic parse_byte(input logic [7:0] b, output deframe_result_type r);
      r = '0;
      r.kind = EV_NONE;
      case (step)
         P_HDR1: begin
            if (b == HDR1) step = P_ADDR0;
            else step = P_HDR0;
         end
         P_ADDR0: begin
            addr_held = {b, 24'h0};
            step = P_ADDR1;
         end
         P_ADDR1: begin
            addr_held[23:16] = b;
            step = P_ADDR2;
         end
         P_ADDR2: begin
            addr_held[15:8] = b;
            step = P_ADDR3;
         end
         P_ADDR3: begin
            addr_held[7:0] = b;
            step = P_IDENT;
         end
         P_IDENT: begin
            sum_acc = {8'h00, b};
            cls_held = classify(b);
            step = P_LEN_HI;
         end
         P_LEN_HI: begin
            sum_acc = sum_acc + b;
            len_held = {b, 8'h00};
            step = P_LEN_LO;
         end
         P_LEN_LO: begin
            sum_acc = sum_acc + b;
            len_held[7:0] = b;
            pay_count = 0;
            if (int'(len_held) > FRAME_MAX || len_held < 16'd2) begin
               r.kind = EV_BADLN;
               step = P_HDR0;
            end else if (len_held == 16'd2) begin
               step = P_SUM_HI;
            end else begin
               step = P_PAYLOAD;
            end
         end
         P_PAYLOAD: begin
            sum_acc = sum_acc + b;
            r.kind = EV_PAY;
            r.pay_byte = b;
            r.pay_index = pay_count[7:0];
            pay_count++;
            if (pay_count >= int'(len_held) - 2) step = P_SUM_HI;
         end
         P_SUM_HI: begin
            chk_hi = b;
            step = P_SUM_LO;
         end
         P_SUM_LO: begin
            if ({chk_hi, b} == sum_acc) r.kind = EV_GOOD;
            else r.kind = EV_BADCS;
            step = P_HDR0;
         end
         default: begin
            if (b == HDR0) step = P_HDR1;
            else step = P_HDR0;
         end
      endcase
      r.address = addr_held;
      r.cls = cls_held;
      r.length = len_held;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < MAX_PRINTED)
         $display("%0t: %s mismatch, got %0h, expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic compare_field(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   // The valid stays high across back-to-back transfers; it is only lowered
   // when a gap is drawn or when settle runs.
   task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                            input event_kind_type typed_kind = EV_NONE);
      int gap;
      deframe_result_type r;
      gap = draw_gap(sender_calm);
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.rx_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      parse_byte(b, r);
      if (typed) r.kind = typed_kind;
      pending_results.push_back(r);
      bytes_sent++;
   endtask

   task automatic send_frame();
      logic [7:0]  frame_bytes [$];
      logic [15:0] length;
      logic [15:0] sum;
      logic [15:0] chk;
      logic [7:0]  ident;
      logic [7:0]  b;
      int          roll;
      int          cut;
      if ($urandom_range(0, 9) == 0) sender_calm = ~sender_calm;
      // Stray bytes between frames, often a lone header byte.
      if ($urandom_range(0, 99) < 15) begin
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 2) == 0) send_byte(HDR0);
            else send_byte(8'($urandom));
         end
      end
      if ($urandom_range(0, 99) < 80) ident = ident_code[$urandom_range(0, 3)];
      else ident = 8'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 8) length = 16'd2;
      else if (roll < 12) length = 16'($urandom_range(0, 1));
      else if (roll < 14) length = 16'(FRAME_MAX);
      else if (roll < 16) length = 16'(FRAME_MAX + 1);
      else if (roll < 20) length = 16'($urandom_range(FRAME_MAX + 1, 16'hFFFF));
      else if (roll < 21) length = 16'hFFFF;
      else length = 16'($urandom_range(3, 24));
      frame_bytes.push_back(HDR0);
      if ($urandom_range(0, 99) < 3) frame_bytes.push_back(8'($urandom));
      else frame_bytes.push_back(HDR1);
      repeat (4) frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(ident);
      frame_bytes.push_back(length[15:8]);
      frame_bytes.push_back(length[7:0]);
      sum = 16'(ident) + 16'(length[15:8]) + 16'(length[7:0]);
      if (length >= 16'd2 && int'(length) <= FRAME_MAX) begin
         repeat (int'(length) - 2) begin
            b = 8'($urandom);
            sum = sum + b;
            frame_bytes.push_back(b);
         end
         chk = sum;
         if ($urandom_range(0, 99) < 15) chk = sum ^ 16'($urandom_range(1, 16'hFFFF));
         frame_bytes.push_back(chk[15:8]);
         frame_bytes.push_back(chk[7:0]);
      end
      // Now and then the frame is cut short and the next one runs into it.
      if ($urandom_range(0, 99) < 5) begin
         cut = $urandom_range(1, frame_bytes.size() - 1);
         while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
      end
      foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
   endtask

   // Lets every pending result drain before the registers are touched.
   task automatic settle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [7:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= value;
      do @(posedge clock); while (!csr_if.ready);
      ident_code[idx] = value;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic apply_codes(input logic [7:0] c_cmd, input logic [7:0] c_data,
                              input logic [7:0] c_ack, input logic [7:0] c_fin);
      csr_write(CSR_CODE_COMMAND, c_cmd);
      csr_write(CSR_CODE_DATA, c_data);
      csr_write(CSR_CODE_ACK, c_ack);
      csr_write(CSR_CODE_END, c_fin);
   endtask

   // Result side: random stalls, one long hold-off, and the field checks.
   initial begin
      deframe_result_type want;
      int stall;
      rsp_if.ready <= 1'b0;
      results_taken = 0;
      receiver_calm = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 49) == 0) receiver_calm = ~receiver_calm;
         stall = draw_gap(receiver_calm);
         if (results_taken == PRESSURE_AT) stall = PRESSURE_CYCLES;
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         results_taken++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result, kind", 32'(rsp_if.event_kind), 32'h0);
         end else begin
            want = pending_results.pop_front();
            compare_field("event_kind", 32'(rsp_if.event_kind), 32'(want.kind));
            compare_field("payload_byte", 32'(rsp_if.payload_byte), 32'(want.pay_byte));
            compare_field("payload_index", 32'(rsp_if.payload_index), 32'(want.pay_index));
            compare_field("frame_address", rsp_if.frame_address, want.address);
            compare_field("packet_class", 32'(rsp_if.packet_class), 32'(want.cls));
            compare_field("frame_length", 32'(rsp_if.frame_length), 32'(want.length));
         end
      end
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > LIMIT_CYCLES) begin
            $display("[fingerprint_packet_deframer] ERROR");
            $finish;
         end
      end
   end

   initial begin
      req_if.valid <= 1'b0;
      req_if.rx_byte <= 8'h00;
      csr_if.valid <= 1'b0;
      csr_if.index <= CSR_CODE_COMMAND;
      csr_if.data <= 8'h00;
      reset <= 1'b1;
      mismatch_count = 0;
      bytes_sent = 0;
      sender_calm = 1'b0;
      step = P_HDR0;
      addr_held = '0;
      cls_held = CLS_COMMAND;
      len_held = '0;
      pay_count = 0;
      sum_acc = '0;
      chk_hi = '0;
      ident_code[CSR_CODE_COMMAND] = 8'd1;
      ident_code[CSR_CODE_DATA] = 8'd2;
      ident_code[CSR_CODE_ACK] = 8'd7;
      ident_code[CSR_CODE_END] = 8'd8;

      // Header hunting with a repeated EF, a frame of length two with the
      // extreme address, and an unknown packet whose length is one too many.
      directed_rows = '{
         '{8'h00, 1'b1, EV_NONE},  '{8'hEF, 1'b0, EV_NONE},  '{8'hEF, 1'b0, EV_NONE},
         '{8'h01, 1'b1, EV_NONE},  '{8'hEF, 1'b0, EV_NONE},  '{8'h01, 1'b0, EV_NONE},
         '{8'hFF, 1'b0, EV_NONE},  '{8'hFF, 1'b0, EV_NONE},  '{8'hFF, 1'b0, EV_NONE},
         '{8'hFF, 1'b0, EV_NONE},  '{8'h01, 1'b0, EV_NONE},  '{8'h00, 1'b0, EV_NONE},
         '{8'h02, 1'b1, EV_NONE},  '{8'h00, 1'b0, EV_NONE},  '{8'h03, 1'b1, EV_GOOD},
         '{8'hEF, 1'b0, EV_NONE},  '{8'h01, 1'b0, EV_NONE},  '{8'h00, 1'b0, EV_NONE},
         '{8'h00, 1'b0, EV_NONE},  '{8'h00, 1'b0, EV_NONE},  '{8'h00, 1'b0, EV_NONE},
         '{8'hFF, 1'b0, EV_NONE},  '{8'h01, 1'b0, EV_NONE},  '{8'h01, 1'b1, EV_BADLN}
      };

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].kind);

      for (int phase = 0; phase < N_PHASES; phase++) begin
         if (phase > 0) begin
            settle();
            case (phase)
               1: apply_codes(8'h00, 8'hFF, HDR0, HDR1);
               2: apply_codes(8'hAA, 8'hAA, 8'hAA, 8'hAA);
               3: apply_codes(8'hFF, 8'h00, 8'hFF, 8'h00);
               default: apply_codes(8'($urandom), 8'($urandom), 8'($urandom),
                                    8'($urandom));
            endcase
         end
         while (bytes_sent < (phase + 1) * ITEMS_PER_PHASE) send_frame();
      end

      settle();
      if (mismatch_count == 0) begin
         $display("[fingerprint_packet_deframer] OK");
      end else begin
         $display("[fingerprint_packet_deframer] ERROR");
      end
      $finish;
   end

endmodule
